/* rtl/core/ezms_pkg.sv */
`default_nettype none

package ezms_pkg;

    localparam int WORD_W      = 16;
    localparam int ARC_W       = 9;
    localparam int COUNT_W     = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int HISTORY_DEPTH_DEFAULT = 4;
    localparam int STAMP_WIDTH_DEFAULT   = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_MIN_PERIOD      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ARC_DEGREES     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MARKS_PER_REV   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TICKS_PER_MS    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TWO_DEGREE_MODE = 3'd4;

    localparam logic [WORD_W-1:0]  MIN_PERIOD_RESET    = 16'd100;
    localparam logic [ARC_W-1:0]   ARC_DEGREES_RESET   = 9'd24;
    localparam logic [COUNT_W-1:0] MARKS_PER_REV_RESET = 8'd15;
    localparam logic [WORD_W-1:0]  TICKS_PER_MS_RESET  = 16'd1000;

    localparam logic [WORD_W-1:0] WORD_MAX = 16'hFFFF;

    typedef struct packed {
        logic [WORD_W-1:0] capture_time;
    } mark_t;

    typedef struct packed {
        logic              overspeed;
        logic              zero_mark;
        logic              sync_failed;
        logic              result_ready;
        logic [WORD_W-1:0] degree_time;
        logic [WORD_W-1:0] degree_reload;
        logic [WORD_W-1:0] degree_compare;
        logic [WORD_W-1:0] rotation_ms;
        logic [WORD_W-1:0] sample_index;
    } result_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

/* rtl/core/ezms_stream_if.sv */
`default_nettype none

interface ezms_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/ezms_serial_div.sv */
`default_nettype none

module ezms_serial_div #(
    parameter int DIVIDEND_W = 18,
    parameter int DIVISOR_W  = ezms_pkg::WORD_W
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [DIVIDEND_W-1:0]   dividend,
    input  wire logic [DIVISOR_W-1:0]    divisor,
    output logic      [DIVIDEND_W-1:0]   quotient,
    output ezms_pkg::div_status_t        status
);
    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [DIVIDEND_W-1:0] quot_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dvsr_reg;

    logic [DIVISOR_W:0]    rem_shift;
    logic                  rem_ge;
    logic [DIVISOR_W:0]    rem_diff;

    // One quotient bit per cycle, restoring form.
    always_comb
    begin
        rem_shift = {rem_reg, quot_reg[DIVIDEND_W-1]};
        rem_ge    = rem_shift >= {1'b0, dvsr_reg};
        rem_diff  = rem_shift - {1'b0, dvsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (count_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CNT_W'(DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[DIVIDEND_W-2:0], rem_ge};
            rem_reg  <= rem_ge ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
        end
    end

    assign quotient    = quot_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

/* rtl/core/encoder_zero_mark_sync_core.sv */
// Encoder zero-mark synchronizer for a disc with one missing tooth.
// The mark channel carries one word per encoder edge: the timer value latched
// at that edge. The result channel returns one word per mark with the clamp
// and zero-mark flags, the per-degree time, the degree timer reload and
// compare values, the last rotation time in milliseconds and the sample index.
// Both channels use valid and ready; a word moves when both are high.
// The user must write the registers through cfg_write, cfg_index and cfg_data
// only while the block is idle; the block itself does not enforce this.
// An unknown index is ignored. The divisions of a mark (per-degree time, ring
// average and, on the zero mark, rotation time) run in turn on one shared
// bit-serial divider W = max(STAMP_WIDTH, 16 + clog2(HISTORY_DEPTH)) bits wide.
// The next mark is taken in the cycle after the result is loaded into the
// output register.
// A held result waits in the output register while the receiver stalls, and a
// new mark is accepted in the meantime; its own result waits for the register.
// Reset clears the history, counters and stamps and loads the register defaults.
`default_nettype none

module encoder_zero_mark_sync_core #(
    parameter int HISTORY_DEPTH = ezms_pkg::HISTORY_DEPTH_DEFAULT,
    parameter int STAMP_WIDTH   = ezms_pkg::STAMP_WIDTH_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [ezms_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ezms_pkg::CFG_DATA_W-1:0]  cfg_data,
    ezms_stream_if.sink                           mark,
    ezms_stream_if.source                         result
);
    localparam int WORD_W   = ezms_pkg::WORD_W;
    localparam int PERIOD_W = (STAMP_WIDTH > WORD_W) ? STAMP_WIDTH : WORD_W;
    localparam int SUM_W    = WORD_W + $clog2(HISTORY_DEPTH);
    localparam int DIV_W    = (PERIOD_W > SUM_W) ? PERIOD_W : SUM_W;
    localparam int SLOT_W   = $clog2(HISTORY_DEPTH);
    localparam int PROD_W   = ezms_pkg::COUNT_W + ezms_pkg::ARC_W;
    localparam int JUDGE_W  = WORD_W + 3;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DIV_T   = 3'd1;
    localparam logic [2:0] S_DIV_AVG = 3'd2;
    localparam logic [2:0] S_DIV_ROT = 3'd3;
    localparam logic [2:0] S_FINISH  = 3'd4;

    logic [2:0] state_reg;

    logic [WORD_W-1:0]               min_period_reg;
    logic [ezms_pkg::ARC_W-1:0]      arc_degrees_reg;
    logic [ezms_pkg::COUNT_W-1:0]    marks_per_rev_reg;
    logic [WORD_W-1:0]               ticks_per_ms_reg;
    logic                            two_degree_reg;

    logic [STAMP_WIDTH-1:0]          last_capture_reg;
    logic [STAMP_WIDTH-1:0]          last_zero_reg;
    logic [WORD_W-1:0]               hist_reg [HISTORY_DEPTH];
    logic [SLOT_W-1:0]               slot_reg;
    logic [SUM_W-1:0]                sum_reg;
    logic [ezms_pkg::COUNT_W-1:0]    mark_count_reg;
    logic [WORD_W-1:0]               rotation_reg;

    logic [STAMP_WIDTH-1:0]          now_reg;
    logic [PERIOD_W-1:0]             t_reg;
    logic [WORD_W-1:0]               idx_reg;
    logic                            over_reg;
    logic                            zero_reg;
    logic                            fail_reg;
    logic                            good_reg;

    logic                            result_valid_reg;
    ezms_pkg::result_t               result_data_reg;

    logic [STAMP_WIDTH-1:0]          now;
    logic [STAMP_WIDTH-1:0]          period_raw;
    logic [STAMP_WIDTH-1:0]          zero_span;
    logic [WORD_W-1:0]               minimum;
    logic                            period_low;
    logic [PERIOD_W-1:0]             period;
    logic [ezms_pkg::ARC_W-1:0]      arc_eff;
    logic [WORD_W-1:0]               tpm_eff;
    logic [ezms_pkg::COUNT_W-1:0]    mark_count_inc;
    logic [PROD_W-1:0]               idx_prod;
    logic [WORD_W-1:0]               idx_sat;

    logic                            accept;
    logic                            div_start;
    logic [DIV_W-1:0]                div_dividend;
    logic [WORD_W-1:0]               div_divisor;
    logic [DIV_W-1:0]                div_quotient;
    ezms_pkg::div_status_t           div_status;

    logic [PERIOD_W-1:0]             t_new;
    logic [WORD_W-1:0]               t_new_sat;
    logic [SUM_W-1:0]                sum_next;
    logic [SLOT_W-1:0]               slot_next;
    logic [WORD_W-1:0]               t_cur_sat;
    logic [WORD_W-1:0]               avg;
    logic [JUDGE_W-1:0]              t_scaled;
    logic [JUDGE_W-1:0]              avg_scaled;
    logic                            is_zero;
    logic [WORD_W-1:0]               rot_sat;
    logic [WORD_W-1:0]               reload_base;
    logic [WORD_W-1:0]               reload;
    logic                            out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_period_reg    <= ezms_pkg::MIN_PERIOD_RESET;
            arc_degrees_reg   <= ezms_pkg::ARC_DEGREES_RESET;
            marks_per_rev_reg <= ezms_pkg::MARKS_PER_REV_RESET;
            ticks_per_ms_reg  <= ezms_pkg::TICKS_PER_MS_RESET;
            two_degree_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ezms_pkg::REG_MIN_PERIOD:
                    min_period_reg <= cfg_data;
                ezms_pkg::REG_ARC_DEGREES:
                    arc_degrees_reg <= cfg_data[ezms_pkg::ARC_W-1:0];
                ezms_pkg::REG_MARKS_PER_REV:
                    marks_per_rev_reg <= cfg_data[ezms_pkg::COUNT_W-1:0];
                ezms_pkg::REG_TICKS_PER_MS:
                    ticks_per_ms_reg <= cfg_data;
                ezms_pkg::REG_TWO_DEGREE_MODE:
                    two_degree_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        now            = STAMP_WIDTH'(mark.data.capture_time);
        period_raw     = now - last_capture_reg;
        zero_span      = now_reg - last_zero_reg;
        minimum        = two_degree_reg ? (min_period_reg >> 1) : min_period_reg;
        period_low     = PERIOD_W'(period_raw) < PERIOD_W'(minimum);
        period         = period_low ? PERIOD_W'(minimum) : PERIOD_W'(period_raw);
        arc_eff        = (arc_degrees_reg == '0) ? ezms_pkg::ARC_W'(1) : arc_degrees_reg;
        tpm_eff        = (ticks_per_ms_reg == '0) ? WORD_W'(1) : ticks_per_ms_reg;
        mark_count_inc = mark_count_reg + ezms_pkg::COUNT_W'(1);
        idx_prod       = PROD_W'(mark_count_inc) * PROD_W'(arc_eff);
        idx_sat        = (idx_prod > PROD_W'(ezms_pkg::WORD_MAX)) ?
                         ezms_pkg::WORD_MAX : idx_prod[WORD_W-1:0];

        t_new     = div_quotient[PERIOD_W-1:0];
        t_new_sat = (t_new > PERIOD_W'(ezms_pkg::WORD_MAX)) ?
                    ezms_pkg::WORD_MAX : t_new[WORD_W-1:0];
        sum_next  = sum_reg - SUM_W'(hist_reg[slot_reg]) + SUM_W'(t_new_sat);
        slot_next = (slot_reg == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_reg + SLOT_W'(1);

        // The zero mark is the one whose time is at least 5/4 of the average.
        t_cur_sat  = (t_reg > PERIOD_W'(ezms_pkg::WORD_MAX)) ?
                     ezms_pkg::WORD_MAX : t_reg[WORD_W-1:0];
        avg        = div_quotient[WORD_W-1:0];
        t_scaled   = {1'b0, t_cur_sat, 2'b00};
        avg_scaled = JUDGE_W'({avg, 2'b00}) + JUDGE_W'(avg);
        is_zero    = (avg != '0) && (t_scaled >= avg_scaled);

        rot_sat = (div_quotient > DIV_W'(ezms_pkg::WORD_MAX)) ?
                  ezms_pkg::WORD_MAX : div_quotient[WORD_W-1:0];

        reload_base = (t_cur_sat == '0) ? '0 : t_cur_sat - WORD_W'(1);
        if (two_degree_reg)
        begin
            reload = reload_base[WORD_W-1] ? ezms_pkg::WORD_MAX :
                     {reload_base[WORD_W-2:0], 1'b0};
        end
        else
        begin
            reload = reload_base;
        end

        out_free = !result_valid_reg || result.ready;
        accept   = mark.valid && (state_reg == S_IDLE);
    end

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = DIV_W'(period);
        div_divisor  = WORD_W'(arc_eff);
        unique case (state_reg) inside
            S_IDLE:
            begin
                div_start = mark.valid;
            end
            S_DIV_T:
            begin
                div_start    = div_status.done;
                div_dividend = DIV_W'(sum_next);
                div_divisor  = WORD_W'(HISTORY_DEPTH);
            end
            S_DIV_AVG:
            begin
                div_start    = div_status.done && is_zero;
                div_dividend = DIV_W'(zero_span);
                div_divisor  = tpm_eff;
            end
            S_DIV_ROT, S_FINISH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    ezms_serial_div #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (WORD_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .status   (div_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            last_capture_reg <= '0;
            last_zero_reg    <= '0;
            slot_reg         <= '0;
            sum_reg          <= '0;
            mark_count_reg   <= '0;
            rotation_reg     <= '0;
            result_valid_reg <= 1'b0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            if (state_reg == S_FINISH && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        last_capture_reg <= now;
                        mark_count_reg   <= mark_count_inc;
                        state_reg        <= S_DIV_T;
                    end
                end
                S_DIV_T:
                begin
                    if (div_status.done)
                    begin
                        hist_reg[slot_reg] <= t_new_sat;
                        slot_reg           <= slot_next;
                        sum_reg            <= sum_next;
                        state_reg          <= S_DIV_AVG;
                    end
                end
                S_DIV_AVG:
                begin
                    if (div_status.done)
                    begin
                        if (is_zero)
                        begin
                            last_zero_reg  <= now_reg;
                            mark_count_reg <= '0;
                            state_reg      <= S_DIV_ROT;
                        end
                        else
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_DIV_ROT:
                begin
                    if (div_status.done)
                    begin
                        rotation_reg <= rot_sat;
                        state_reg    <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    now_reg  <= now;
                    over_reg <= period_low;
                    idx_reg  <= idx_sat;
                    zero_reg <= 1'b0;
                    fail_reg <= 1'b0;
                    good_reg <= 1'b0;
                end
            end
            S_DIV_T:
            begin
                if (div_status.done)
                begin
                    t_reg <= t_new;
                end
            end
            S_DIV_AVG:
            begin
                if (div_status.done && is_zero)
                begin
                    // Halving the period halves the per-degree time exactly.
                    t_reg    <= t_reg >> 1;
                    zero_reg <= 1'b1;
                    fail_reg <= mark_count_reg != marks_per_rev_reg;
                    good_reg <= mark_count_reg == marks_per_rev_reg;
                    idx_reg  <= '0;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    result_data_reg.overspeed      <= over_reg;
                    result_data_reg.zero_mark      <= zero_reg;
                    result_data_reg.sync_failed    <= fail_reg;
                    result_data_reg.result_ready   <= good_reg;
                    result_data_reg.degree_time    <= t_cur_sat;
                    result_data_reg.degree_reload  <= reload;
                    result_data_reg.degree_compare <= reload >> 1;
                    result_data_reg.rotation_ms    <= rotation_reg;
                    result_data_reg.sample_index   <= idx_reg;
                end
            end
            S_DIV_ROT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign mark.ready   = (state_reg == S_IDLE);
    assign result.valid = result_valid_reg;
    assign result.data  = result_data_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_status.busy)
        else $error("Divider started while a division is still running.");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |->
            (state_reg == S_DIV_T || state_reg == S_DIV_AVG || state_reg == S_DIV_ROT))
        else $error("Division finished outside a divide state.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg) == S_FINISH)
        else $error("Result word raised without finishing a mark.");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |->
            (result_data_reg.zero_mark ?
                (result_data_reg.sample_index == '0 &&
                 (result_data_reg.sync_failed ^ result_data_reg.result_ready)) :
                (!result_data_reg.sync_failed && !result_data_reg.result_ready)))
        else $error("Zero-mark flags in the result word are inconsistent.");

endmodule

`default_nettype wire

/* tb/encoder_zero_mark_sync_core_test.sv */
`default_nettype none

module encoder_zero_mark_sync_core_test;

    localparam int WORD_W  = ezms_pkg::WORD_W;
    localparam int INDEX_W = ezms_pkg::CFG_INDEX_W;
    localparam int DATA_W  = ezms_pkg::CFG_DATA_W;

    localparam logic [INDEX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [INDEX_W-1:0] REG_SPARE_LAST  = 3'd7;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 200;
    localparam int STALL_CYCLES   = 500;
    localparam int RING_DEPTH     = ezms_pkg::HISTORY_DEPTH_DEFAULT;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [INDEX_W-1:0] cfg_index;
    logic [DATA_W-1:0]  cfg_data;

    ezms_stream_if #(.payload_t(ezms_pkg::mark_t))   mark_bus ();
    ezms_stream_if #(.payload_t(ezms_pkg::result_t)) result_bus ();

    encoder_zero_mark_sync_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mark      (mark_bus),
        .result    (result_bus)
    );

    logic [WORD_W-1:0]            cfg_min_period;
    logic [ezms_pkg::ARC_W-1:0]   cfg_arc;
    logic [ezms_pkg::COUNT_W-1:0] cfg_marks;
    logic [WORD_W-1:0]            cfg_tpm;
    logic                         cfg_two_deg;

    logic [WORD_W-1:0]            prev_stamp = '0;
    logic [WORD_W-1:0]            prev_zero_stamp = '0;
    logic [WORD_W-1:0]            rot_ms = '0;
    logic [WORD_W-1:0]            deg_ring [RING_DEPTH] = '{default: '0};
    int                           ring_slot = 0;
    logic [ezms_pkg::COUNT_W-1:0] mark_cnt = '0;

    ezms_pkg::result_t expected_results [$];
    logic [WORD_W-1:0] pending_marks [$];
    logic [WORD_W-1:0] stamp_cursor;

    int   fail_count = 0;
    int   quiet_cycles;
    logic source_idle_en;
    logic sink_idle_en;
    logic stall_kick;
    logic long_stall;

    function automatic logic [WORD_W-1:0] clip_word(input int unsigned value);
        return (value > ezms_pkg::WORD_MAX) ? ezms_pkg::WORD_MAX : value[WORD_W-1:0];
    endfunction

    function automatic ezms_pkg::result_t predict_mark(input logic [WORD_W-1:0] stamp);
        ezms_pkg::result_t r;
        int unsigned       arc;
        int unsigned       tpm;
        int unsigned       floor_ticks;
        int unsigned       period;
        int unsigned       per_deg;
        int unsigned       ring_sum;
        int unsigned       ring_avg;
        int unsigned       reload;
        logic [WORD_W-1:0] span;
        r = '0;
        arc = (cfg_arc == 0) ? 1 : 32'(cfg_arc);
        tpm = (cfg_tpm == 0) ? 1 : 32'(cfg_tpm);
        floor_ticks = cfg_two_deg ? 32'(cfg_min_period >> 1) : 32'(cfg_min_period);
        span = stamp - prev_stamp;
        period = 32'(span);
        prev_stamp = stamp;
        if (period < floor_ticks)
        begin
            period = floor_ticks;
            r.overspeed = 1'b1;
        end
        per_deg = period / arc;
        mark_cnt = mark_cnt + 1'b1;
        r.sample_index = clip_word(mark_cnt * arc);
        deg_ring[ring_slot] = per_deg[WORD_W-1:0];
        ring_slot = (ring_slot + 1) % RING_DEPTH;
        ring_sum = 0;
        foreach (deg_ring[i])
            ring_sum += 32'(deg_ring[i]);
        ring_avg = ring_sum / RING_DEPTH;
        if (ring_avg != 0 && (per_deg * 4) / ring_avg >= 5)
        begin
            r.zero_mark = 1'b1;
            period = period >> 1;
            per_deg = period / arc;
            span = stamp - prev_zero_stamp;
            rot_ms = clip_word(32'(span) / tpm);
            prev_zero_stamp = stamp;
            r.sync_failed = (mark_cnt != cfg_marks);
            r.result_ready = !r.sync_failed;
            mark_cnt = '0;
            r.sample_index = '0;
        end
        reload = (per_deg != 0) ? per_deg - 1 : 0;
        if (cfg_two_deg)
            reload = 32'(clip_word(reload * 2));
        r.degree_time = per_deg[WORD_W-1:0];
        r.degree_reload = reload[WORD_W-1:0];
        r.degree_compare = reload[WORD_W:1];
        r.rotation_ms = rot_ms;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic write_reg(input logic [INDEX_W-1:0] index,
                             input logic [DATA_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        unique case (index)
            ezms_pkg::REG_MIN_PERIOD:      cfg_min_period = value;
            ezms_pkg::REG_ARC_DEGREES:     cfg_arc = value[ezms_pkg::ARC_W-1:0];
            ezms_pkg::REG_MARKS_PER_REV:   cfg_marks = value[ezms_pkg::COUNT_W-1:0];
            ezms_pkg::REG_TICKS_PER_MS:    cfg_tpm = value;
            ezms_pkg::REG_TWO_DEGREE_MODE: cfg_two_deg = value[0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [DATA_W-1:0] min_ticks,
                            input logic [DATA_W-1:0] arc,
                            input logic [DATA_W-1:0] marks,
                            input logic [DATA_W-1:0] tpm,
                            input logic [DATA_W-1:0] two_deg);
        write_reg(ezms_pkg::REG_MIN_PERIOD, min_ticks);
        write_reg(ezms_pkg::REG_ARC_DEGREES, arc);
        write_reg(ezms_pkg::REG_MARKS_PER_REV, marks);
        write_reg(ezms_pkg::REG_TICKS_PER_MS, tpm);
        write_reg(ezms_pkg::REG_TWO_DEGREE_MODE, two_deg);
        write_reg(INDEX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                  DATA_W'($urandom));
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic drain_marks();
        while (pending_marks.size() != 0 || mark_bus.valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Each revolution is a train of jittered, near-evenly spaced marks closed by one double gap.
    task automatic queue_revolutions(input int count, input int unsigned spacing);
        int          teeth;
        int          k;
        int unsigned step;
        while (count > 0)
        begin
            teeth = (cfg_marks == 0) ? 1 : int'(cfg_marks);
            if ($urandom_range(0, 99) < 15)
                teeth = teeth + int'($urandom_range(0, 2)) - 1;
            if (teeth < 1)
                teeth = 1;
            for (k = 1; k <= teeth && count > 0; k++)
            begin
                step = ((k == teeth) ? 2 * spacing : spacing) + $urandom_range(0, spacing / 32);
                if ($urandom_range(0, 99) < 6)
                    stamp_cursor = WORD_W'($urandom);
                else
                    stamp_cursor = WORD_W'(stamp_cursor + step);
                pending_marks.push_back(stamp_cursor);
                count--;
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_bus.valid <= 1'b0;
            mark_bus.data  <= '0;
        end
        else
        begin
            if (mark_bus.valid && mark_bus.ready)
                expected_results.push_back(predict_mark(mark_bus.data.capture_time));
            if (!mark_bus.valid || mark_bus.ready)
            begin
                if (pending_marks.size() != 0 &&
                    !(source_idle_en && $urandom_range(0, 99) < 30))
                begin
                    mark_bus.valid <= 1'b1;
                    mark_bus.data  <= ezms_pkg::mark_t'(pending_marks.pop_front());
                end
                else
                begin
                    mark_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        ezms_pkg::result_t want;
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
        end
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result word with nothing expected, expected none, actual %p",
                             $time, result_bus.data);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("overspeed", want.overspeed, result_bus.data.overspeed);
                    check_field("zero_mark", want.zero_mark, result_bus.data.zero_mark);
                    check_field("sync_failed", want.sync_failed, result_bus.data.sync_failed);
                    check_field("result_ready", want.result_ready,
                                result_bus.data.result_ready);
                    check_field("degree_time", want.degree_time, result_bus.data.degree_time);
                    check_field("degree_reload", want.degree_reload,
                                result_bus.data.degree_reload);
                    check_field("degree_compare", want.degree_compare,
                                result_bus.data.degree_compare);
                    check_field("rotation_ms", want.rotation_ms, result_bus.data.rotation_ms);
                    check_field("sample_index", want.sample_index,
                                result_bus.data.sample_index);
                end
            end
            result_bus.ready <= !long_stall && !(sink_idle_en && $urandom_range(0, 99) < 30);
        end
    end

    // The receiver refuses words for a long stretch so the block backs up into its input.
    initial
    begin
        long_stall = 1'b0;
        wait (stall_kick);
        @(posedge clk);
        long_stall <= 1'b1;
        repeat (STALL_CYCLES) @(posedge clk);
        long_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (mark_bus.valid && mark_bus.ready) ||
            (result_bus.valid && result_bus.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("encoder_zero_mark_sync_core_test: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int          n;
        int          k;
        int unsigned arc_pick;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        source_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        stall_kick = 1'b0;
        stamp_cursor = '0;
        cfg_min_period = ezms_pkg::MIN_PERIOD_RESET;
        cfg_arc = ezms_pkg::ARC_DEGREES_RESET;
        cfg_marks = ezms_pkg::MARKS_PER_REV_RESET;
        cfg_tpm = ezms_pkg::TICKS_PER_MS_RESET;
        cfg_two_deg = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        pending_marks = '{16'h0000, 16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA};
        stamp_cursor = 16'hAAAA;
        queue_revolutions(18, 2400);
        drain_marks();

        set_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd0);
        queue_revolutions(40, $urandom_range(2, 3000));
        drain_marks();

        set_regs(ezms_pkg::WORD_MAX, 16'd360, 16'd255, ezms_pkg::WORD_MAX, 16'd1);
        queue_revolutions(30, 20000);
        drain_marks();

        set_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd1);
        queue_revolutions(40, $urandom_range(1000, 30000));
        drain_marks();

        // Marks closer than one tick per degree hold the ring average at zero, random stamp jumps apart.
        set_regs(16'd0, 16'd360, 16'd15, ezms_pkg::TICKS_PER_MS_RESET, 16'd0);
        queue_revolutions(20, 100);
        drain_marks();

        // A steady train wraps the mark count and saturates the sample index.
        set_regs(ezms_pkg::MIN_PERIOD_RESET, 16'd360, 16'd15,
                 ezms_pkg::TICKS_PER_MS_RESET, 16'd0);
        source_idle_en <= 1'b0;
        sink_idle_en <= 1'b0;
        for (k = 0; k < 270; k++)
        begin
            stamp_cursor = WORD_W'(stamp_cursor + 36000 + $urandom_range(0, 300));
            pending_marks.push_back(stamp_cursor);
        end
        drain_marks();
        source_idle_en <= 1'b1;
        sink_idle_en <= 1'b1;

        for (n = 0; n < 6; n++)
        begin
            arc_pick = $urandom_range(1, 360);
            set_regs(DATA_W'($urandom_range(1, 4000)),
                     DATA_W'(arc_pick | ($urandom_range(0, 127) << ezms_pkg::ARC_W)),
                     DATA_W'($urandom_range(2, 40) |
                             ($urandom_range(0, 255) << ezms_pkg::COUNT_W)),
                     DATA_W'($urandom_range(0, 65535)),
                     DATA_W'($urandom_range(0, 1) | ($urandom_range(0, 32767) << 1)));
            queue_revolutions(80, $urandom_range(arc_pick * 4, 30000));
            if (n == 1)
                stall_kick <= 1'b1;
            drain_marks();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("encoder_zero_mark_sync_core_test: PASS");
        else
            $display("encoder_zero_mark_sync_core_test: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
